/* src/lfid_pkg.sv */
// Shared constants for the lowest-free identifier allocator.
package lfid_pkg;

  localparam int DEF_ID_COUNT = 4096;
  localparam int DEF_ID_BASE  = 300;

  localparam int PID_W     = 16;
  localparam int PID_RES_W = 13;
  localparam int STATUS_W  = 2;

  // One memory word holds the used bits of this many identifiers.
  localparam int WORD_W = 64;
  localparam int BIT_W  = 6;
  localparam int GRP_W  = 8;
  localparam int GRP_N  = WORD_W / GRP_W;
  localparam int GSEL_W = 3;
  localparam int LSEL_W = 3;

  localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BADREL = 2'd2;

endpackage

/* src/lfid_ffz.sv */
// Finds the lowest set bit of a word of free flags, in two levels of eight.
module lfid_ffz
  import lfid_pkg::*;
(
  input  logic [WORD_W-1:0] free_bits,
  output logic              found,
  output logic [BIT_W-1:0]  pos
);

  logic [GRP_N-1:0]  grp_any;
  logic [GSEL_W-1:0] sel_g;
  logic [GRP_W-1:0]  grp_bits;
  logic [LSEL_W-1:0] sel_b;

  always_comb begin
    for (int g = 0; g < GRP_N; g++) begin
      grp_any[g] = |free_bits[g*GRP_W +: GRP_W];
    end
  end

  always_comb begin
    sel_g = '0;
    for (int g = GRP_N - 1; g >= 0; g--) begin
      if (grp_any[g]) begin
        sel_g = GSEL_W'(g);
      end
    end
  end

  assign grp_bits = free_bits[sel_g*GRP_W +: GRP_W];

  always_comb begin
    sel_b = '0;
    for (int b = GRP_W - 1; b >= 0; b--) begin
      if (grp_bits[b]) begin
        sel_b = LSEL_W'(b);
      end
    end
  end

  assign found = |grp_any;
  assign pos   = {sel_g, sel_b};

endmodule

/* src/lowest_free_id_allocator.sv */
// Lowest-free identifier allocator: used-bit memory of 64-bit words with a read-modify-write FSM.
// Allocate: words are read from word 0 up until one holds a free bit, which is set; the pool is
// full after all WORDS words (64 by default) are read; one word read per cycle.
// Release: one read, then a write-back that clears the bit if it was in use.
// A new word is accepted in the cycle that done is high. The receiver cannot stall.
// After reset a clearing pass writes zeros to all WORDS words, busy high.
module lowest_free_id_allocator
  import lfid_pkg::*;
#(
  parameter int ID_COUNT = DEF_ID_COUNT,
  parameter int ID_BASE  = DEF_ID_BASE
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic                 mode,
  input  logic [PID_W-1:0]     pid,
  output logic                 done,
  output logic [PID_RES_W-1:0] pid_res,
  output logic [STATUS_W-1:0]  status
);

  localparam int WORDS     = (ID_COUNT + WORD_W - 1) / WORD_W;
  localparam int ADDR_W    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int CNT_W     = $clog2(WORDS + 1);
  localparam int OFF_W     = PID_W + 1;
  localparam int LAST_BITS = ID_COUNT - (WORDS - 1) * WORD_W;
  localparam logic [WORD_W-1:0] LAST_MASK = (LAST_BITS == WORD_W) ? {WORD_W{1'b1}} :
      ((WORD_W'(1) << LAST_BITS) - WORD_W'(1));
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(WORDS - 1);

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_SCAN  = 4'b0100,
    S_REL   = 4'b1000
  } state_t;

  state_t            state;
  logic [ADDR_W-1:0] clr_addr;
  logic [CNT_W-1:0]  scan_cnt;
  logic [ADDR_W-1:0] chk_addr;
  logic [PID_W-1:0]  req_pid;
  logic              req_ok;
  logic [BIT_W-1:0]  req_bit;
  logic [ADDR_W-1:0] req_addr;

  logic [WORD_W-1:0] mem [WORDS];
  logic [WORD_W-1:0] rdata;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [WORD_W-1:0] wr_data;

  logic [OFF_W-1:0]  offset;
  logic              in_range;
  logic [WORD_W-1:0] word_mask;
  logic [WORD_W-1:0] free_bits;
  logic              found;
  logic [BIT_W-1:0]  pos;
  logic [OFF_W-1:0]  alloc_id;
  logic              rel_hit;

  assign busy = (state != S_IDLE);

  assign offset   = {1'b0, pid} - OFF_W'(ID_BASE);
  assign in_range = ({1'b0, pid} >= OFF_W'(ID_BASE)) && (offset < OFF_W'(ID_COUNT));

  // Bits past the end of the pool in the last word count as used.
  assign word_mask = (chk_addr == LAST_ADDR) ? LAST_MASK : {WORD_W{1'b1}};
  assign free_bits = ~rdata & word_mask;
  assign alloc_id  = OFF_W'(ID_BASE) + OFF_W'({chk_addr, pos});
  assign rel_hit   = req_ok && rdata[req_bit];

  lfid_ffz u_ffz (
    .free_bits (free_bits),
    .found     (found),
    .pos       (pos)
  );

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    unique case (state)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_addr;
      end
      S_IDLE: begin
        if (start) begin
          rd_en   = 1'b1;
          rd_addr = mode ? offset[ADDR_W+BIT_W-1:BIT_W] : '0;
        end
      end
      S_SCAN: begin
        if (found) begin
          wr_en   = 1'b1;
          wr_addr = chk_addr;
          wr_data = rdata | (WORD_W'(1) << pos);
        end else if (scan_cnt < CNT_W'(WORDS)) begin
          rd_en   = 1'b1;
          rd_addr = scan_cnt[ADDR_W-1:0];
        end
      end
      S_REL: begin
        if (rel_hit) begin
          wr_en   = 1'b1;
          wr_addr = req_addr;
          wr_data = rdata & ~(WORD_W'(1) << req_bit);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + ADDR_W'(1);
          if (clr_addr == LAST_ADDR) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            if (mode) begin
              req_pid  <= pid;
              req_ok   <= in_range;
              req_bit  <= offset[BIT_W-1:0];
              req_addr <= offset[ADDR_W+BIT_W-1:BIT_W];
              state    <= S_REL;
            end else begin
              scan_cnt <= CNT_W'(1);
              chk_addr <= '0;
              state    <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (found) begin
            done    <= 1'b1;
            pid_res <= alloc_id[PID_RES_W-1:0];
            status  <= STATUS_OK;
            state   <= S_IDLE;
          end else if (scan_cnt < CNT_W'(WORDS)) begin
            chk_addr <= scan_cnt[ADDR_W-1:0];
            scan_cnt <= scan_cnt + CNT_W'(1);
          end else begin
            done    <= 1'b1;
            pid_res <= '0;
            status  <= STATUS_FULL;
            state   <= S_IDLE;
          end
        end
        S_REL: begin
          done    <= 1'b1;
          pid_res <= req_pid[PID_RES_W-1:0];
          status  <= rel_hit ? STATUS_OK : STATUS_BADREL;
          state   <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A result is only delivered once the FSM is back in idle.
  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("done raised while busy");

  // An accepted word always leaves the idle state.
  assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("accepted word did not start work");

  // Reset always starts the clearing pass.
  assert property (@(posedge clk) rst |=> (state == S_CLEAR))
    else $error("reset did not start the clearing pass");

  // A full pool reports identifier zero.
  assert property (@(posedge clk) disable iff (rst)
      (done && status == STATUS_FULL) |-> (pid_res == '0))
    else $error("full pool with nonzero identifier");

  // The memory is never written while the allocator sits idle.
  assert property (@(posedge clk) disable iff (rst) (state == S_IDLE) |-> !wr_en)
    else $error("memory write in idle");

endmodule
